### rtl/mt64_pkg.sv
package mt64_pkg;

    localparam int unsigned StateWords = 312;
    localparam int unsigned MidOffset  = 156;
    localparam int unsigned AddrW      = 9;

    localparam logic [AddrW-1:0] LastAddr      = AddrW'(StateWords - 1);
    localparam logic [AddrW-1:0] MidAddr       = AddrW'(MidOffset);
    localparam logic [AddrW-1:0] FullIndex     = AddrW'(StateWords);
    localparam logic [AddrW-1:0] UnseededIndex = AddrW'(StateWords + 1);

    localparam logic [63:0] TwistMatrix = 64'hB502_6F5A_A966_19E9;
    localparam logic [31:0] SeedMultLo  = 32'h4C95_7F2D;
    localparam logic [31:0] SeedMultHi  = 32'h5851_F42D;
    localparam logic [63:0] UpperMask   = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LowerMask   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TemperB     = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TemperC     = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TemperD     = 64'hFFF7_EEE0_0000_0000;
    localparam logic [63:0] DefaultSeed = 64'd5489;

    // opcode of an input word
    localparam logic OpSeed = 1'b0;
    localparam logic OpDraw = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic seed_start;   // load seed, write word 0, count from 1
        logic use_default;  // seed with the default value
        logic seed_xor;     // x = p ^ (p >> 62)
        logic mul_ll;       // product x_lo * m_lo
        logic mul_hl;       // product x_hi * m_lo, acc = prev product + count
        logic mul_lh;       // product x_lo * m_hi, acc += prev product << 32
        logic seed_write;   // write acc + (product << 32)
        logic tw_start;     // read word 0, count from 0
        logic tw_load_cur;  // current word from read port a
        logic tw_read;      // read next and middle words
        logic tw_write;     // write twisted word
        logic draw_read;    // read word at index
        logic draw_out;     // temper into output register
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic idx_unseeded;
        logic idx_full;
        logic out_free;
    } t_dp_sts;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] y;
        y = w;
        y = y ^ ((y >> 29) & TemperB);
        y = y ^ ((y << 17) & TemperC);
        y = y ^ ((y << 37) & TemperD);
        y = y ^ (y >> 43);
        return y;
    endfunction

endpackage

### rtl/mt64_ctrl.sv
module mt64_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_op,
    output logic              o_ready,
    input  mt64_pkg::t_dp_sts i_sts,
    output mt64_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SEED_XOR = 12'b0000_0000_0010,
        S_SEED_M0  = 12'b0000_0000_0100,
        S_SEED_M1  = 12'b0000_0000_1000,
        S_SEED_M2  = 12'b0000_0001_0000,
        S_SEED_WR  = 12'b0000_0010_0000,
        S_TW_PRE   = 12'b0000_0100_0000,
        S_TW_LOAD  = 12'b0000_1000_0000,
        S_TW_RD    = 12'b0001_0000_0000,
        S_TW_WR    = 12'b0010_0000_0000,
        S_DR_RD    = 12'b0100_0000_0000,
        S_DR_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_draw_pend, n_draw_pend;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_draw_pend = r_draw_pend;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_op == mt64_pkg::OpSeed) || i_sts.idx_unseeded) begin
                        // an unseeded draw seeds with the default first
                        o_cmd.seed_start  = 1'b1;
                        o_cmd.use_default = (i_op == mt64_pkg::OpDraw);
                        n_draw_pend       = (i_op == mt64_pkg::OpDraw);
                        n_state           = S_SEED_XOR;
                    end else if (i_sts.idx_full) begin
                        n_state = S_TW_PRE;
                    end else begin
                        o_cmd.draw_read = 1'b1;
                        n_state         = S_DR_OUT;
                    end
                end
            end
            S_SEED_XOR: begin
                o_cmd.seed_xor = 1'b1;
                n_state        = S_SEED_M0;
            end
            S_SEED_M0: begin
                o_cmd.mul_ll = 1'b1;
                n_state      = S_SEED_M1;
            end
            S_SEED_M1: begin
                o_cmd.mul_hl = 1'b1;
                n_state      = S_SEED_M2;
            end
            S_SEED_M2: begin
                o_cmd.mul_lh = 1'b1;
                n_state      = S_SEED_WR;
            end
            S_SEED_WR: begin
                o_cmd.seed_write = 1'b1;
                if (!i_sts.cnt_last) begin
                    n_state = S_SEED_XOR;
                end else if (r_draw_pend) begin
                    n_state = S_TW_PRE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TW_PRE: begin
                o_cmd.tw_start = 1'b1;
                n_state        = S_TW_LOAD;
            end
            S_TW_LOAD: begin
                o_cmd.tw_load_cur = 1'b1;
                n_state           = S_TW_RD;
            end
            S_TW_RD: begin
                o_cmd.tw_read = 1'b1;
                n_state       = S_TW_WR;
            end
            S_TW_WR: begin
                o_cmd.tw_write = 1'b1;
                n_state        = i_sts.cnt_last ? S_DR_RD : S_TW_RD;
            end
            S_DR_RD: begin
                o_cmd.draw_read = 1'b1;
                n_state         = S_DR_OUT;
            end
            S_DR_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.draw_out = 1'b1;
                    n_draw_pend    = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_draw_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_draw_pend <= n_draw_pend;
        end
    end

endmodule

### rtl/mt64_dp.sv
module mt64_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_seed_value,
    input  logic              i_ready,
    input  mt64_pkg::t_dp_cmd i_cmd,
    output mt64_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic [63:0]       o_random_word,
    output logic              o_mem_wr
);

    localparam int unsigned AW = mt64_pkg::AddrW;

    logic [63:0]   r_mem [0:mt64_pkg::StateWords-1];
    logic [63:0]   r_rd_a, r_rd_b;
    logic [63:0]   r_prev, r_x, r_prod, r_acc, r_cur, r_out;
    logic          r_out_vld;
    logic [AW-1:0] r_cnt, r_idx;

    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic          rd_en_a, rd_en_b, wr_en;
    logic [63:0]   wr_data, seed_src, seed_word, tw_word, y;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [AW-1:0] nx_addr, md_addr;

    // seed recurrence, low 64 bits of the product from three 32x32 parts
    assign seed_src  = i_cmd.use_default ? mt64_pkg::DefaultSeed : i_seed_value;
    assign mul_a     = i_cmd.mul_hl ? r_x[63:32] : r_x[31:0];
    assign mul_b     = i_cmd.mul_lh ? mt64_pkg::SeedMultHi : mt64_pkg::SeedMultLo;
    assign prod      = 64'(mul_a) * 64'(mul_b);
    assign seed_word = r_acc + {r_prod[31:0], 32'b0};

    // twist of one word
    assign nx_addr = (r_cnt == mt64_pkg::LastAddr) ? '0 : r_cnt + 1'b1;
    assign md_addr = (r_cnt < mt64_pkg::MidAddr) ? r_cnt + mt64_pkg::MidAddr
                                                 : r_cnt - mt64_pkg::MidAddr;
    assign y       = (r_cur & mt64_pkg::UpperMask) | (r_rd_a & mt64_pkg::LowerMask);
    assign tw_word = r_rd_b ^ (y >> 1) ^ (y[0] ? mt64_pkg::TwistMatrix : 64'd0);

    // memory port selection
    always_comb begin
        rd_en_a   = i_cmd.tw_start || i_cmd.tw_read || i_cmd.draw_read;
        rd_en_b   = i_cmd.tw_read;
        rd_addr_a = r_idx;
        if (i_cmd.tw_start) begin
            rd_addr_a = '0;
        end else if (i_cmd.tw_read) begin
            rd_addr_a = nx_addr;
        end
        rd_addr_b = md_addr;
        wr_en     = i_cmd.seed_start || i_cmd.seed_write || i_cmd.tw_write;
        wr_addr   = i_cmd.seed_start ? '0 : r_cnt;
        wr_data   = tw_word;
        if (i_cmd.seed_start) begin
            wr_data = seed_src;
        end else if (i_cmd.seed_write) begin
            wr_data = seed_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_prev <= seed_src;
        end else if (i_cmd.seed_write) begin
            r_prev <= seed_word;
        end
        if (i_cmd.seed_xor) begin
            r_x <= r_prev ^ (r_prev >> 62);
        end
        if (i_cmd.mul_ll || i_cmd.mul_hl || i_cmd.mul_lh) begin
            r_prod <= prod;
        end
        if (i_cmd.mul_hl) begin
            r_acc <= r_prod + 64'(r_cnt);
        end else if (i_cmd.mul_lh) begin
            r_acc <= r_acc + {r_prod[31:0], 32'b0};
        end
        if (i_cmd.tw_load_cur || i_cmd.tw_write) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.draw_out) begin
            r_out <= mt64_pkg::temper(r_rd_a);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= mt64_pkg::UnseededIndex;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.seed_start) begin
                r_cnt <= AW'(1);
            end else if (i_cmd.tw_start) begin
                r_cnt <= '0;
            end else if (i_cmd.seed_write || i_cmd.tw_write) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.seed_write && (r_cnt == mt64_pkg::LastAddr)) begin
                r_idx <= mt64_pkg::FullIndex;
            end else if (i_cmd.tw_write && (r_cnt == mt64_pkg::LastAddr)) begin
                r_idx <= '0;
            end else if (i_cmd.draw_out) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.draw_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_last     = (r_cnt == mt64_pkg::LastAddr);
    assign o_sts.idx_unseeded = (r_idx == mt64_pkg::UnseededIndex);
    assign o_sts.idx_full     = (r_idx >= mt64_pkg::FullIndex);
    assign o_sts.out_free     = !r_out_vld || i_ready;

    assign o_valid       = r_out_vld;
    assign o_random_word = r_out;
    assign o_mem_wr      = wr_en;

endmodule

### rtl/mersenne_twister_64_generator.sv
// channel  | valid   | ready   | payload
// ---------+---------+---------+------------------------------
// input    | i_valid | o_ready | i_op, i_seed_value
// output   | o_valid | i_ready | o_random_word
//
// a draw from a ready state reads its word and tempers it once output is free
// a seed works through each state word in xor, multiply and write steps,
//   using the shared 32x32 multiplier for three partial products per word
// a twist reads two words per step from the state memory
// synchronous active-low reset; the state memory holds no reset value
// o_ready stays low while a word is in work; a held output blocks only
//   the next result, not acceptance of the following word
module mersenne_twister_64_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [63:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_random_word
);

    mt64_pkg::t_dp_cmd cmd;
    mt64_pkg::t_dp_sts sts;
    logic              mem_wr;

    // sequencer for seeding, twisting and drawing
    mt64_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // state memory, seed multiplier, twist and temper logic, output register
    mt64_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_value  (i_seed_value),
        .i_ready       (i_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_random_word (o_random_word),
        .o_mem_wr      (mem_wr)
    );

    // a seed word never makes a result appear right after it
    a_seed_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == mt64_pkg::OpSeed)) |=> !$rose(o_valid))
        else $error("result raised after a seed word");

    // a new result only appears as the controller returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result raised while a word is still in work");

    // state memory is never written while a word is being read for output
    a_no_write_on_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_wr && (cmd.draw_read || cmd.draw_out)))
        else $error("state write during draw");

    // input is not taken while busy
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on two adjacent cycles");

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one pending word for the sender
    typedef struct {
        logic        op;
        logic [63:0] seed;
        bit          drain;     // hold this word until every drawn word is back
    } t_request;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_op         = mt64_pkg::OpDraw;
    logic [63:0] i_seed_value = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_random_word;

    t_request    request_q[$];      // words still to send
    logic [63:0] tempered_due[$];   // drawn words not yet seen at the output

    int n_total   = 0;
    int n_sent    = 0;
    int n_seeds   = 0;
    int n_draws   = 0;
    int n_twists  = 0;
    int n_checked = 0;
    int n_errors  = 0;
    int send_gap  = 0;
    int recv_gap  = 0;

    // no idling near the end, and one quiet stretch out of every three
    logic quiet;
    assign quiet = (n_sent + 150 >= n_total) || ((n_sent / 97) % 3 == 2);

    // shadow copy of the generator state
    logic [63:0] mt_words [mt64_pkg::StateWords];
    int unsigned mt_pos = mt64_pkg::UnseededIndex;

    mersenne_twister_64_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_seed_value (i_seed_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_random_word(o_random_word)
    );

    // fill the state from a seed by the multiply-xor recurrence
    function automatic void mt_seed(input logic [63:0] s);
        logic [63:0] p;
        mt_words[0] = s;
        for (int n = 1; n < mt64_pkg::StateWords; n++) begin
            p           = mt_words[n-1];
            mt_words[n] = {mt64_pkg::SeedMultHi, mt64_pkg::SeedMultLo} * (p ^ (p >> 62))
                          + 64'(n);
        end
        // next draw twists first
        mt_pos = mt64_pkg::FullIndex;
    endfunction

    // apply one accepted word to the shadow state, queue the tempered word of a draw
    function automatic void mt_accept(input logic op, input logic [63:0] s);
        logic [63:0] y;
        logic [63:0] v;
        int unsigned nx;
        int unsigned md;
        if (op == mt64_pkg::OpSeed) begin
            mt_seed(s);
            n_seeds++;
        end else begin
            if (mt_pos >= mt64_pkg::StateWords) begin
                // unseeded draw falls back to the default seed
                if (mt_pos != mt64_pkg::StateWords)
                    mt_seed(mt64_pkg::DefaultSeed);
                // twist all words in place, in order
                for (int unsigned n = 0; n < mt64_pkg::StateWords; n++) begin
                    nx = (n + 1) % mt64_pkg::StateWords;
                    md = (n + mt64_pkg::MidOffset) % mt64_pkg::StateWords;
                    y  = (mt_words[n] & mt64_pkg::UpperMask)
                         | (mt_words[nx] & mt64_pkg::LowerMask);
                    v  = mt_words[md] ^ (y >> 1);
                    if (y[0])
                        v = v ^ mt64_pkg::TwistMatrix;
                    mt_words[n] = v;
                end
                mt_pos = 0;
                n_twists++;
            end
            y = mt_words[mt_pos];
            mt_pos++;
            // tempering
            y = y ^ ((y >> 29) & mt64_pkg::TemperB);
            y = y ^ ((y << 17) & mt64_pkg::TemperC);
            y = y ^ ((y << 37) & mt64_pkg::TemperD);
            y = y ^ (y >> 43);
            tempered_due.push_back(y);
            n_draws++;
        end
    endfunction

    function automatic void add(input logic op, input logic [63:0] s, input bit drain);
        t_request r;
        r.op    = op;
        r.seed  = s;
        r.drain = drain;
        request_q.push_back(r);
    endfunction

    // seeds lean toward the extremes and single set bits
    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // safety net in case the block hangs
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // sender: one word at a time from request_q
    always @(posedge i_clk) begin
        t_request r;
        logic     nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && o_ready) begin
                // accepted: predict from the values held this cycle
                mt_accept(i_op, i_seed_value);
                n_sent    <= n_sent + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() > 0 &&
                             !(request_q[0].drain && tempered_due.size() != 0)) begin
                    r = request_q.pop_front();
                    i_op         <= r.op;
                    i_seed_value <= r.seed;
                    nxt_valid    = 1'b1;
                    // idle burst after this word goes through
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // receiver: check each word against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (tempered_due.size() == 0) begin
                    n_errors++;
                    $display("time %0t: random_word expected none, actual %h",
                             $time, o_random_word);
                end else begin
                    want = tempered_due.pop_front();
                    n_checked++;
                    if (o_random_word !== want) begin
                        n_errors++;
                        $display("time %0t: random_word expected %h, actual %h",
                                 $time, want, o_random_word);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                // start a stall burst
                recv_gap = $urandom_range(0, 3);
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int burst;

        // directed: draw before any seed runs on the default seed
        add(mt64_pkg::OpDraw, '1, 0);
        add(mt64_pkg::OpDraw, '0, 0);
        add(mt64_pkg::OpDraw, {$urandom, $urandom}, 0);
        // all-zero seed, after a drain so no draw is in flight
        add(mt64_pkg::OpSeed, '0, 1);
        add(mt64_pkg::OpDraw, '0, 0);
        add(mt64_pkg::OpDraw, '1, 0);
        // all-ones seed drops the rest of the current block
        add(mt64_pkg::OpSeed, '1, 0);
        add(mt64_pkg::OpDraw, {$urandom, $urandom}, 0);
        // explicit default seed must repeat the opening words
        add(mt64_pkg::OpSeed, mt64_pkg::DefaultSeed, 0);
        add(mt64_pkg::OpDraw, '0, 0);
        add(mt64_pkg::OpDraw, '0, 0);
        // back-to-back seeds, only the second one counts
        add(mt64_pkg::OpSeed, 64'd1, 0);
        add(mt64_pkg::OpSeed, 64'h8000_0000_0000_0000, 0);
        add(mt64_pkg::OpDraw, '0, 0);
        add(mt64_pkg::OpSeed, {$urandom, $urandom}, 1);
        add(mt64_pkg::OpDraw, '1, 0);
        add(mt64_pkg::OpDraw, {$urandom, $urandom}, 0);

        // random: seeds followed by draw runs, some long enough to cross twists
        while (request_q.size() < 1400) begin
            add(mt64_pkg::OpSeed, pick_seed(), $urandom_range(0, 3) == 0);
            burst = ($urandom_range(0, 6) == 0) ? $urandom_range(250, 700)
                                                : $urandom_range(0, 30);
            if (request_q.size() + burst > 1420)
                burst = 1420 - request_q.size();
            repeat (burst)
                add(mt64_pkg::OpDraw, {$urandom, $urandom}, $urandom_range(0, 199) == 0);
        end
        n_total = request_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total || tempered_due.size() != 0)
            @(posedge i_clk);
        // last word may be a seed still in work: watch for stray output
        repeat (2000) @(posedge i_clk);

        $display("sent %0d words: %0d seeds, %0d draws over %0d state twists",
                 n_sent, n_seeds, n_draws, n_twists);
        $display("checked %0d output words, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
